// ===== rtl/core/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative cache tag block.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int WAYS         = 8;
   localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W       = WAY_W;
   localparam int MAX_SET_BITS = 6;
   localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NUM_SETS     = 1 << MAX_SET_BITS;

   localparam int ADDR_W = 32;
   localparam int TAG_W  = 32;
   localparam int OB_W   = 3;
   localparam int SB_W   = 3;
   localparam int CSR_W  = 3;

   localparam logic [OB_W-1:0] OFFSET_BITS_RESET    = 3'd5;
   localparam logic [SB_W-1:0] SET_INDEX_BITS_RESET = 3'd1;

   typedef enum logic [0:0] {
      CSR_OFFSET_BITS    = 1'b0,
      CSR_SET_INDEX_BITS = 1'b1
   } csr_index_type;

   // one set: tag, age and valid bit of every way
   typedef struct packed {
      logic [WAYS-1:0][TAG_W-1:0]  tag;
      logic [WAYS-1:0][RANK_W-1:0] rank;
      logic [WAYS-1:0]             valid;
   } row_type;

   localparam int ROW_W = $bits(row_type);

endpackage

// ===== rtl/core/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/set_assoc_lru_cache_tags.sv =====
// An accepted transfer is registered into stage 2 and then into the result
// registers. Throughput: one access per cycle; a result stall holds the whole
// pipe. The set RAM is read at accept and written back when the access leaves
// stage 2, with a bypass for back-to-back accesses to one set.
// Reset: per-set fill flags cleared so every line reads invalid with age zero,
// offset_bits = 5, set_index_bits = 1, pipe empty.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag lookup and true-LRU update of an 8-way set-associative cache.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags
   import salc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write,
   input  csr_index_type     csr_index,
   input  logic [CSR_W-1:0]  csr_data,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_address,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_hit,
   output logic [WAY_W-1:0]  rsp_way_used,
   output logic [ADDR_W-1:0] rsp_access_address
);

   logic [OB_W-1:0]   offset_bits_ff;
   logic [SB_W-1:0]   set_index_bits_ff;

   // a set never written since reset reads as all ways invalid
   logic [NUM_SETS-1:0] set_used_ff;

   logic              s2_valid_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [SET_W-1:0]  s2_set_ff;
   logic [TAG_W-1:0]  s2_tag_ff;
   logic              s2_used_ff;
   logic              fwd_ff;
   row_type           fwd_row_ff;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [WAY_W-1:0]  rsp_way_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;

   logic              advance;
   logic [SB_W-1:0]   sb_sat;
   logic [ADDR_W-1:0] req_shifted;
   logic [SET_W-1:0]  req_set;
   logic [SB_W:0]     tag_shift;
   logic [TAG_W-1:0]  req_tag;
   logic              fwd_in;

   logic [ROW_W-1:0]  ram_q;
   row_type           row_rd;
   row_type           row_wr;
   logic [WAYS-1:0]   valid_row;
   logic [WAYS-1:0]   match;
   logic              s2_hit;
   logic              any_free;
   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  free_way;
   logic [WAY_W-1:0]  lru_way;
   logic [RANK_W-1:0] oldest;
   logic [WAY_W-1:0]  s2_way;
   logic [RANK_W:0]   old_age;

   // ---------------------------------------------------------------- control
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign advance   = !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff    <= OFFSET_BITS_RESET;
         set_index_bits_ff <= SET_INDEX_BITS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_OFFSET_BITS:    offset_bits_ff    <= csr_data;
            CSR_SET_INDEX_BITS: set_index_bits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------- address split
   always_comb begin
      sb_sat      = (set_index_bits_ff > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS)
                                                              : set_index_bits_ff;
      req_shifted = req_address >> offset_bits_ff;
      req_set     = SET_W'(req_shifted) & ~({SET_W{1'b1}} << sb_sat);
      tag_shift   = {1'b0, offset_bits_ff} + {1'b0, sb_sat};
      req_tag     = TAG_W'(req_address >> tag_shift);
      // the item in stage 2 writes its set back at this same edge
      fwd_in      = s2_valid_ff && (s2_set_ff == req_set);
   end

   // -------------------------------------------------------- tag / age RAM
   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (advance && s2_valid_ff),
      .wr_addr (s2_set_ff),
      .wr_data (row_wr),
      .rd_en   (advance),
      .rd_addr (req_set),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         set_used_ff <= '0;
      end else if (advance && s2_valid_ff) begin
         set_used_ff[s2_set_ff] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= req_valid;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_addr_ff <= req_address;
         s2_set_ff  <= req_set;
         s2_tag_ff  <= req_tag;
         s2_used_ff <= set_used_ff[req_set];
         fwd_row_ff <= row_wr;
      end
   end

   always_comb begin
      row_rd    = fwd_ff ? fwd_row_ff
                         : (s2_used_ff ? row_type'(ram_q) : row_type'('0));
      valid_row = row_rd.valid;

      for (int w = 0; w < WAYS; w++) begin
         match[w] = valid_row[w] && (row_rd.tag[w] == s2_tag_ff);
      end
      s2_hit   = |match;
      any_free = ~&valid_row;

      // lowest-numbered matching / free way
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
         if (!valid_row[w]) begin
            free_way = WAY_W'(w);
         end
      end

      // oldest way, lowest index on a tie
      lru_way = '0;
      oldest  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (row_rd.rank[w] > oldest) begin
            oldest  = row_rd.rank[w];
            lru_way = WAY_W'(w);
         end
      end

      priority if (s2_hit) begin
         s2_way  = hit_way;
         old_age = {1'b0, row_rd.rank[hit_way]};
      end else if (any_free) begin
         s2_way  = free_way;
         old_age = (RANK_W + 1)'(WAYS);
      end else begin
         s2_way  = lru_way;
         old_age = {1'b0, row_rd.rank[lru_way]};
      end

      row_wr = row_rd;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == s2_way) begin
            row_wr.rank[w]  = '0;
            row_wr.valid[w] = 1'b1;
            if (!s2_hit) begin
               row_wr.tag[w] = s2_tag_ff;
            end
         end else if (valid_row[w] && ({1'b0, row_rd.rank[w]} < old_age)) begin
            row_wr.rank[w] = row_rd.rank[w] + RANK_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff  <= s2_hit;
         rsp_way_ff  <= s2_way;
         rsp_addr_ff <= s2_addr_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_way_used       = rsp_way_ff;
   assign rsp_access_address = rsp_addr_ff;

`ifndef SYNTH
   // an accepted transfer always lands in stage 2
   a_accept_to_s2 : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s2_valid_ff)
      else $error("accepted request lost before stage 2");

   // a fill never evicts a valid line while a free way exists
   a_fill_free_way : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_hit && any_free) |-> !valid_row[s2_way])
      else $error("fill chose a valid way while a free way exists");

   // the way used by an access is valid in the written-back set
   a_way_used_valid : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> row_wr.valid[s2_way])
      else $error("way used not marked valid");

   // a stalled result holds stage 2 in place
   a_stall_holds_s2 : assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && req_stall) |=> (s2_valid_ff && $stable(s2_addr_ff)))
      else $error("stage 2 moved during a stall");
`endif

endmodule
